// ----- design/tdpt_pkg.sv -----
// Shared types for the trial-division prime tester.
// No dependencies; used by tdpt_rem_unit and trial_division_prime_test.
package tdpt_pkg;

   // Status beat from the remainder unit back to the sequencer
   typedef struct packed {
      logic done;   // one-cycle pulse: remainder is final
      logic zero;   // remainder equals zero (valid with done)
   } rem_status_type;

endpackage

// ----- design/tdpt_rem_unit.sv -----
// Bit-serial restoring remainder unit: dividend % divisor, one bit a cycle.
// Depends on tdpt_pkg (rem_status_type).
module tdpt_rem_unit #(
   parameter int NUMBER_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [NUMBER_WIDTH-1:0]   dividend,
   input  logic [NUMBER_WIDTH-1:0]   divisor,
   output tdpt_pkg::rem_status_type  status
);

   localparam int W  = NUMBER_WIDTH;
   localparam int IW = $clog2(W);

   logic          run_ff;
   logic [IW-1:0] idx_ff;
   logic [W-1:0]  shift_ff;
   logic [W-1:0]  rem_ff;
   logic          done_ff;
   logic          zero_ff;

   logic [W:0]    trial_in;
   logic [W-1:0]  rem_in;

   // bring down the next dividend bit, subtract when it fits
   always_comb begin
      trial_in = {rem_ff, shift_ff[W-1]};
      if (trial_in >= {1'b0, divisor}) begin
         trial_in = trial_in - {1'b0, divisor};
      end
      rem_in = trial_in[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
         end else if (run_ff && idx_ff == '0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff   <= '0;
         shift_ff <= dividend;
         idx_ff   <= IW'(W - 1);
      end else if (run_ff) begin
         rem_ff   <= rem_in;
         shift_ff <= {shift_ff[W-2:0], 1'b0};
         idx_ff   <= idx_ff - IW'(1);
         zero_ff  <= (rem_in == '0);
      end
   end

   assign status.done = done_ff;
   assign status.zero = zero_ff;

endmodule

// ----- design/trial_division_prime_test.sv -----
// Top level of the trial-division prime tester: sequencer around a single
// bit-serial remainder unit. Depends on tdpt_pkg and tdpt_rem_unit.
//
// Usage:
//   Drive req_candidate and raise start while busy is low; that edge takes
//   the beat. busy falls at the edge that raises rsp_valid, so the next beat
//   can be taken during the strobe cycle.
//   The result appears on rsp_is_prime / rsp_smallest_divisor for exactly
//   one cycle, flagged by rsp_valid. The receiver cannot stall it; capture
//   it on that cycle. smallest_divisor is 0 for a prime and for 0 or 1.
// Sequence:
//   Candidates below 2 strobe in the cycle after the accepting edge. Otherwise
//   the sequencer tries d = 2, 3 and upward while d*d <= candidate; each trial
//   is a check state that launches the remainder unit, its bit-serial run and
//   a wait state that sees the done pulse. The strobe follows the first trial
//   that divides, or for a prime the check that finds d*d > candidate.
//   One candidate is in flight at a time.
// Reset:
//   Synchronous, active high; returns to idle and drops any search in flight.
module trial_division_prime_test #(
   parameter int NUMBER_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [NUMBER_WIDTH-1:0] req_candidate,
   output logic                    rsp_valid,
   output logic                    rsp_is_prime,
   output logic [NUMBER_WIDTH-1:0] rsp_smallest_divisor
);

   localparam int W = NUMBER_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WAIT
   } state_type;

   state_type state_ff;

   logic [W-1:0] num_ff;     // candidate under test
   logic [W-1:0] div_ff;     // current trial divisor
   logic [W+1:0] sq_ff;      // div_ff squared
   logic         go_ff;
   logic         valid_ff;
   logic         prime_ff;
   logic [W-1:0] sdiv_ff;

   logic [W+1:0] sq_in;
   logic [W-1:0] div_in;
   logic         past_root;

   tdpt_pkg::rem_status_type rem_status;

   tdpt_rem_unit #(
      .NUMBER_WIDTH (W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .go       (go_ff),
      .dividend (num_ff),
      .divisor  (div_ff),
      .status   (rem_status)
   );

   // track d*d incrementally: (d+1)^2 = d^2 + 2d + 1
   assign div_in    = div_ff + W'(1);
   assign sq_in     = sq_ff + (W+2)'({div_ff, 1'b1});
   assign past_root = sq_ff > {2'b00, num_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         go_ff    <= 1'b0;
         valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  num_ff <= req_candidate;
                  div_ff <= W'(2);
                  sq_ff  <= (W+2)'(4);
                  if (req_candidate[W-1:1] == '0) begin
                     // zero and one: not prime, no divisor
                     valid_ff <= 1'b1;
                     prime_ff <= 1'b0;
                     sdiv_ff  <= '0;
                  end else begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if (past_root) begin
                  // no divisor up to the root: prime
                  valid_ff <= 1'b1;
                  prime_ff <= 1'b1;
                  sdiv_ff  <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  go_ff    <= 1'b1;
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (rem_status.done) begin
                  if (rem_status.zero) begin
                     valid_ff <= 1'b1;
                     prime_ff <= 1'b0;
                     sdiv_ff  <= div_ff;
                     state_ff <= ST_IDLE;
                  end else begin
                     // advance to the next trial divisor
                     div_ff   <= div_in;
                     sq_ff    <= sq_in;
                     state_ff <= ST_CHECK;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = valid_ff;
   assign rsp_is_prime         = prime_ff;
   assign rsp_smallest_divisor = sdiv_ff;

endmodule
